// ===== design/vfst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vfst_pkg;

    // APB register map: 64-bit registers at byte address 8*index
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;
    localparam int VEC_W  = 63;

    typedef enum logic [2:0] {
        REG_CAM    = 3'd0,
        REG_FWD    = 3'd1,
        REG_RGT    = 3'd2,
        REG_UP     = 3'd3,
        REG_DEPTH  = 3'd4,
        REG_SLOPE  = 3'd5,
        REG_SPHERE = 3'd6
    } reg_idx_t;

    localparam logic [VEC_W-1:0]  CAM_RST    = '0;
    localparam logic [VEC_W-1:0]  FWD_RST    = 63'd524288;
    localparam logic [VEC_W-1:0]  RGT_RST    = 63'd524288;
    localparam logic [VEC_W-1:0]  UP_RST     = '0;
    localparam logic [DATA_W-1:0] DEPTH_RST  = '0;
    localparam logic [DATA_W-1:0] SLOPE_RST  = '0;
    localparam logic [DATA_W-1:0] SPHERE_RST = '0;

    // datapath widths
    localparam int LANE_W    = 21;  // packed vector lane / point coordinate
    localparam int RAD_W     = 20;
    localparam int OP_W      = 22;  // point - camera
    localparam int PROD_W    = 43;  // OP_W x LANE_W
    localparam int DOT_W     = 45;  // sum of three products
    localparam int FAC_W     = 32;
    localparam int RADFAC_W  = 52;  // RAD_W + FAC_W
    localparam int BOUND_W   = 34;  // near - radius, far + radius
    localparam int SLOPE_FRAC = 16;
    localparam int FWD_SPLIT = 22;  // forward split point for slope multiply
    localparam int FWD_HI_W  = DOT_W - FWD_SPLIT;
    localparam int PLO_W     = FWD_SPLIT + FAC_W;
    localparam int PHI_W     = FWD_HI_W + FAC_W + 1;

    typedef struct packed {
        logic [VEC_W-1:0]  cam;
        logic [VEC_W-1:0]  fwd_dir;
        logic [VEC_W-1:0]  rgt_dir;
        logic [VEC_W-1:0]  up_dir;
        logic [DATA_W-1:0] depth;
        logic [DATA_W-1:0] slope;
        logic [DATA_W-1:0] sphere;
    } cfg_t;

    // dot-product front end to limit test back end
    typedef struct packed {
        logic                      valid;
        logic signed [DOT_W-1:0]   fwd;
        logic signed [DOT_W-1:0]   rgt;
        logic signed [DOT_W-1:0]   upv;
        logic [RADFAC_W-1:0]       radfac_r;
        logic [RADFAC_W-1:0]       radfac_u;
        logic signed [BOUND_W-1:0] near_lim;
        logic signed [BOUND_W-1:0] far_lim;
    } dot_out_t;

    function automatic logic signed [LANE_W-1:0] get_lane(
        input logic [VEC_W-1:0] v,
        input int               k
    );
        return v[LANE_W*k +: LANE_W];
    endfunction

endpackage

`default_nettype wire

// ===== design/view_frustum_sphere_test.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sphere-versus-view-frustum test (radar method). Each item is a sphere
// center (point_x/y/z, signed Q12.8) and radius (unsigned Q12.8), launched
// with a one-cycle start pulse; busy never rises, so an item may be launched
// in every cycle. The answer appears on inside_res with done high for exactly
// one cycle, in launch order; the receiver cannot stall, so nothing ever
// backs up. The pipeline stages are camera offset, lane products,
// dot-product sums, depth check with a split slope multiply, two limit
// additions and the side compare. Camera, basis vectors, depth range and
// slope/sphere factors live in 64-bit APB registers at byte address 8*index
// and must only be written while no item is in flight.
module view_frustum_sphere_test
    import vfst_pkg::*;
#(
    parameter int DIR_FRAC_BITS = 19
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    // item in
    input  logic                     start,
    output logic                     busy,
    input  logic signed [LANE_W-1:0] point_x,
    input  logic signed [LANE_W-1:0] point_y,
    input  logic signed [LANE_W-1:0] point_z,
    input  logic [RAD_W-1:0]         radius,
    // result out
    output logic                     done,
    output logic                     inside_res
);

    cfg_t     cfg;
    dot_out_t dot_q;
    logic     accept;

    // fully pipelined, never stalls
    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;

    vfst_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // stages 1-3
    vfst_dot u_dot (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (accept),
        .point_x  (point_x),
        .point_y  (point_y),
        .point_z  (point_z),
        .radius   (radius),
        .dout     (dot_q)
    );

    // stages 4-7
    vfst_test #(
        .DIR_FRAC_BITS (DIR_FRAC_BITS)
    ) u_test (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .din        (dot_q),
        .done       (done),
        .inside_res (inside_res)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##7 done)
        else $error("item result missing");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 7))
        else $error("result without item");

endmodule

`default_nettype wire

// ===== design/vfst_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vfst_regs
    import vfst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_CAM:    cfg_next.cam     = pwdata[VEC_W-1:0];
                REG_FWD:    cfg_next.fwd_dir = pwdata[VEC_W-1:0];
                REG_RGT:    cfg_next.rgt_dir = pwdata[VEC_W-1:0];
                REG_UP:     cfg_next.up_dir  = pwdata[VEC_W-1:0];
                REG_DEPTH:  cfg_next.depth   = pwdata;
                REG_SLOPE:  cfg_next.slope   = pwdata;
                REG_SPHERE: cfg_next.sphere  = pwdata;
                default:    cfg_next = cfg_reg;  // unmapped index: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cam     <= CAM_RST;
            cfg_reg.fwd_dir <= FWD_RST;
            cfg_reg.rgt_dir <= RGT_RST;
            cfg_reg.up_dir  <= UP_RST;
            cfg_reg.depth   <= DEPTH_RST;
            cfg_reg.slope   <= SLOPE_RST;
            cfg_reg.sphere  <= SPHERE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_CAM:    prdata = {1'b0, cfg_reg.cam};
            REG_FWD:    prdata = {1'b0, cfg_reg.fwd_dir};
            REG_RGT:    prdata = {1'b0, cfg_reg.rgt_dir};
            REG_UP:     prdata = {1'b0, cfg_reg.up_dir};
            REG_DEPTH:  prdata = cfg_reg.depth;
            REG_SLOPE:  prdata = cfg_reg.slope;
            REG_SPHERE: prdata = cfg_reg.sphere;
            default:    prdata = '0;
        endcase
    end

    a_depth_wr: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && idx == REG_DEPTH |=> cfg_reg.depth == $past(pwdata))
        else $error("depth register write lost");

endmodule

`default_nettype wire

// ===== design/vfst_dot.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Stages 1-3: camera offset, nine lane products, dot-product sums.
module vfst_dot
    import vfst_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     in_valid,
    input  logic signed [LANE_W-1:0] point_x,
    input  logic signed [LANE_W-1:0] point_y,
    input  logic signed [LANE_W-1:0] point_z,
    input  logic [RAD_W-1:0]         radius,
    output dot_out_t                 dout
);

    logic                     v1_reg;
    logic signed [OP_W-1:0]   op_reg [3];
    logic signed [OP_W-1:0]   op_next [3];
    logic [RAD_W-1:0]         rad1_reg;

    logic                     v2_reg;
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [PROD_W-1:0] prod_next [3][3];
    logic [RADFAC_W-1:0]      radfac_r_reg;
    logic [RADFAC_W-1:0]      radfac_u_reg;
    logic [RAD_W-1:0]         rad2_reg;

    dot_out_t                 dout_reg;
    dot_out_t                 dout_next;

    logic signed [LANE_W-1:0] pt [3];
    logic signed [LANE_W-1:0] dir_lane [3][3];
    logic [LANE_W*3-1:0]      dirs [3];

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    assign dirs[0] = cfg.fwd_dir;
    assign dirs[1] = cfg.rgt_dir;
    assign dirs[2] = cfg.up_dir;

    // stage 1: offset from camera
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            op_next[k] = OP_W'(pt[k]) - OP_W'(get_lane(cfg.cam, k));
        end
    end

    // stage 2: products, one per lane and direction
    always_comb
    begin
        for (int d = 0; d < 3; d++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dir_lane[d][k]  = get_lane(dirs[d], k);
                prod_next[d][k] = PROD_W'(op_reg[k]) * PROD_W'(dir_lane[d][k]);
            end
        end
    end

    // stage 3: sums and widened depth bounds
    always_comb
    begin
        dout_next.valid    = v2_reg;
        dout_next.fwd      = DOT_W'(prod_reg[0][0]) + DOT_W'(prod_reg[0][1])
                           + DOT_W'(prod_reg[0][2]);
        dout_next.rgt      = DOT_W'(prod_reg[1][0]) + DOT_W'(prod_reg[1][1])
                           + DOT_W'(prod_reg[1][2]);
        dout_next.upv      = DOT_W'(prod_reg[2][0]) + DOT_W'(prod_reg[2][1])
                           + DOT_W'(prod_reg[2][2]);
        dout_next.radfac_r = radfac_r_reg;
        dout_next.radfac_u = radfac_u_reg;
        dout_next.near_lim = $signed(BOUND_W'(cfg.depth[31:0]))
                           - $signed(BOUND_W'(rad2_reg));
        dout_next.far_lim  = $signed(BOUND_W'(cfg.depth[63:32]))
                           + $signed(BOUND_W'(rad2_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            dout_reg <= '0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            dout_reg <= dout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        rad1_reg     <= radius;
        prod_reg     <= prod_next;
        radfac_r_reg <= RADFAC_W'(rad1_reg) * RADFAC_W'(cfg.sphere[31:0]);
        radfac_u_reg <= RADFAC_W'(rad1_reg) * RADFAC_W'(cfg.sphere[63:32]);
        rad2_reg     <= rad1_reg;
    end

    assign dout = dout_reg;

endmodule

`default_nettype wire

// ===== design/vfst_test.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Stages 4-7: depth check, split slope multiply, side limits, final compare.
module vfst_test
    import vfst_pkg::*;
#(
    parameter int DIR_FRAC_BITS = 19
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  dot_out_t din,
    output logic     done,
    output logic     inside_res
);

    localparam int CW  = ((DOT_W > BOUND_W + DIR_FRAC_BITS) ?
                          DOT_W : BOUND_W + DIR_FRAC_BITS) + 1;
    localparam int T2W = RADFAC_W + DIR_FRAC_BITS;
    localparam int AW  = ((T2W > PLO_W) ? T2W : PLO_W) + 1;
    localparam int PSW = PHI_W + FWD_SPLIT;
    localparam int LW  = ((AW > PSW) ? AW : PSW) + 2;
    localparam int LHW = DOT_W + SLOPE_FRAC + 1;

    // stage 4
    logic                    v4_reg;
    logic                    depth4_reg;
    logic [PLO_W-1:0]        plo4_reg [2];
    logic signed [PHI_W-1:0] phi4_reg [2];
    logic [DOT_W-1:0]        mag4_reg [2];
    logic [RADFAC_W-1:0]     radfac4_reg [2];

    logic signed [CW-1:0]    fwd_c;
    logic signed [CW-1:0]    near_c;
    logic signed [CW-1:0]    far_c;
    logic                    depth_ok;
    logic [FWD_SPLIT-1:0]    fwd_lo;
    logic signed [FWD_HI_W-1:0] fwd_hi;
    logic [FAC_W-1:0]        slope [2];
    logic signed [DOT_W-1:0] side [2];
    logic [PLO_W-1:0]        plo_next [2];
    logic signed [PHI_W-1:0] phi_next [2];
    logic [DOT_W-1:0]        mag_next [2];

    // stage 5
    logic                    v5_reg;
    logic                    depth5_reg;
    logic [AW-1:0]           a5_reg [2];
    logic signed [PHI_W-1:0] phi5_reg [2];
    logic [DOT_W-1:0]        mag5_reg [2];

    // stage 6
    logic                    v6_reg;
    logic                    depth6_reg;
    logic signed [LW-1:0]    lim6_reg [2];
    logic [DOT_W-1:0]        mag6_reg [2];

    // stage 7
    logic                    done_reg;
    logic                    inside_reg;
    logic                    inside_next;

    assign slope[0] = cfg.slope[31:0];
    assign slope[1] = cfg.slope[63:32];
    assign side[0]  = din.rgt;
    assign side[1]  = din.upv;

    always_comb
    begin
        fwd_c    = CW'(din.fwd);
        near_c   = CW'(din.near_lim) <<< DIR_FRAC_BITS;
        far_c    = CW'(din.far_lim) <<< DIR_FRAC_BITS;
        depth_ok = (fwd_c >= near_c) && (fwd_c <= far_c);
        fwd_lo   = din.fwd[FWD_SPLIT-1:0];
        fwd_hi   = din.fwd[DOT_W-1:FWD_SPLIT];
        for (int s = 0; s < 2; s++)
        begin
            plo_next[s] = PLO_W'(fwd_lo) * PLO_W'(slope[s]);
            phi_next[s] = PHI_W'(fwd_hi) * $signed(PHI_W'(slope[s]));
            mag_next[s] = side[s][DOT_W-1] ? DOT_W'(~side[s] + 1'b1)
                                           : DOT_W'(side[s]);
        end
    end

    // lhs = |side| * 2^16 against lim = rad*factor*2^DIR_FRAC_BITS + slope*fwd
    always_comb
    begin
        inside_next = depth6_reg;
        for (int s = 0; s < 2; s++)
        begin
            if ($signed(LW'({1'b0, mag6_reg[s], SLOPE_FRAC'(0)})) > lim6_reg[s])
            begin
                inside_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v4_reg   <= din.valid;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            done_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        depth4_reg <= depth_ok;
        depth5_reg <= depth4_reg;
        depth6_reg <= depth5_reg;
        for (int s = 0; s < 2; s++)
        begin
            plo4_reg[s] <= plo_next[s];
            phi4_reg[s] <= phi_next[s];
            mag4_reg[s] <= mag_next[s];
            a5_reg[s]   <= AW'({radfac4_reg[s], DIR_FRAC_BITS'(0)}) + AW'(plo4_reg[s]);
            phi5_reg[s] <= phi4_reg[s];
            mag5_reg[s] <= mag4_reg[s];
            lim6_reg[s] <= $signed(LW'(a5_reg[s])) + (LW'(phi5_reg[s]) <<< FWD_SPLIT);
            mag6_reg[s] <= mag5_reg[s];
        end
        radfac4_reg[0] <= din.radfac_r;
        radfac4_reg[1] <= din.radfac_u;
        if (v6_reg)
        begin
            inside_reg <= inside_next;
        end
    end

    assign done       = done_reg;
    assign inside_res = inside_reg;

    a_depth_cull: assert property (@(posedge clk) disable iff (!rst_n)
        v6_reg && !depth6_reg |=> !inside_res)
        else $error("item outside depth range reported inside");

    a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
        din.valid |-> ##4 done)
        else $error("item lost in limit stages");

    a_lhs_width: assert property (@(posedge clk) disable iff (!rst_n)
        v6_reg |-> LHW < LW)
        else $error("side compare width too narrow");

endmodule

`default_nettype wire
